@@ sv/mf_pkg.sv @@
package mf_pkg;

	// Geometry limits
	localparam int MaxWidth  = 1024;
	localparam int AddrW     = $clog2(MaxWidth);
	localparam int PixW      = 8;
	localparam int WidthW    = 11;
	localparam int HeightW   = 16;
	localparam int RowW      = HeightW + 1;
	localparam int CfgIdxW   = 1;
	localparam int CfgDataW  = 16;
	localparam int FifoDepth = 4;

	localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
	localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

	typedef enum logic [0:0] {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [PixW-1:0] pix_t;
	typedef logic [2:0][PixW-1:0] col_t;   // [row]
	typedef logic [8:0][PixW-1:0] win9_t;  // [col*3 + row]

	// Classified item handed from the front end to the line/window stage
	typedef struct packed {
		logic [AddrW-1:0] col;
		pix_t             pix;
		logic             first_col;
		logic             use_up;
		logic             use_mid;
		logic             emit;
		logic             last;
	} job_t;

endpackage

@@ sv/mf_if.sv @@
interface mf_in_if;
	logic                      valid;
	logic                      ready;
	logic [0:0]                opcode;
	logic [mf_pkg::PixW-1:0]   pixel;

	modport source(output valid, opcode, pixel, input ready);
	modport sink(input valid, opcode, pixel, output ready);
endinterface

interface mf_out_if;
	logic                      valid;
	logic                      ready;
	logic [mf_pkg::PixW-1:0]   median_value;
	logic                      last_of_frame;

	modport source(output valid, median_value, last_of_frame, input ready);
	modport sink(input valid, median_value, last_of_frame, output ready);
endinterface

interface mf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mf_pkg::CfgIdxW-1:0]    index;
	logic [mf_pkg::CfgDataW-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ sv/mf_front.sv @@
module mf_front (
	input  logic          clk,
	input  logic          arst_n,
	mf_in_if.sink         pixels,
	mf_cfg_if.sink        cfg,
	output logic          job_valid,
	input  logic          job_ready,
	output mf_pkg::job_t  job
);

	logic [mf_pkg::WidthW-1:0]  width_q;
	logic [mf_pkg::HeightW-1:0] height_q;
	logic [mf_pkg::AddrW-1:0]   col_q;
	logic [mf_pkg::RowW-1:0]    row_q;

	logic [mf_pkg::WidthW-1:0]  w_eff;
	logic [mf_pkg::WidthW-1:0]  w_m1;
	logic [mf_pkg::RowW-1:0]    h_eff;
	logic [mf_pkg::RowW-1:0]    h_p1;
	logic [mf_pkg::AddrW-1:0]   c_eff;
	logic [mf_pkg::WidthW-1:0]  c_plus;
	logic                       first;
	logic                       last;
	logic [mf_pkg::AddrW-1:0]   col_n;
	logic [mf_pkg::RowW-1:0]    row_n;
	logic [mf_pkg::RowW-1:0]    row_inc;
	logic                       push;

	assign cfg.ready    = 1'b1;
	assign pixels.ready = job_ready;
	assign job_valid    = pixels.valid;
	assign push         = pixels.valid && job_ready;

	// Clamp geometry to the supported range
	always_comb begin
		if (width_q == '0)
			w_eff = mf_pkg::WidthW'(1);
		else if (width_q > mf_pkg::WidthW'(mf_pkg::MaxWidth))
			w_eff = mf_pkg::WidthW'(mf_pkg::MaxWidth);
		else
			w_eff = width_q;
		h_eff = (height_q == '0) ? mf_pkg::RowW'(1) : {1'b0, height_q};
		h_p1  = h_eff + mf_pkg::RowW'(1);
		w_m1  = w_eff - mf_pkg::WidthW'(1);
	end

	always_comb begin
		c_eff   = ({1'b0, col_q} >= w_eff) ? w_m1[mf_pkg::AddrW-1:0] : col_q;
		c_plus  = {1'b0, c_eff} + mf_pkg::WidthW'(1);
		first   = (c_eff == '0);
		last    = first && (row_q == h_p1);
		row_inc = row_q + mf_pkg::RowW'(1);

		job.col       = c_eff;
		job.pix       = (pixels.opcode == mf_pkg::OP_PIXEL && row_q < h_eff) ?
		                pixels.pixel : '0;
		job.first_col = first;
		job.use_up    = (row_q >= mf_pkg::RowW'(2));
		job.use_mid   = (row_q != '0);
		job.emit      = first ? (row_q >= mf_pkg::RowW'(2) && row_q <= h_p1)
		                      : (row_q != '0 && row_q <= h_eff);
		job.last      = last;

		if (last) begin
			col_n = '0;
			row_n = '0;
		end else if (c_plus >= w_eff) begin
			col_n = '0;
			row_n = row_inc;
		end else begin
			col_n = c_plus[mf_pkg::AddrW-1:0];
			row_n = row_q;
		end
		if (row_n > h_p1) begin
			col_n = '0;
			row_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf_pkg::WidthReset;
			height_q <= mf_pkg::HeightReset;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (mf_pkg::reg_idx_t'(cfg.index))
					mf_pkg::REG_WIDTH:  width_q  <= cfg.data[mf_pkg::WidthW-1:0];
					mf_pkg::REG_HEIGHT: height_q <= cfg.data[mf_pkg::HeightW-1:0];
					default: ;
				endcase
			end
			if (push) begin
				col_q <= col_n;
				row_q <= row_n;
			end
		end
	end

endmodule

@@ sv/mf_queue.sv @@
module mf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mf_pkg::job_t  in_job,
	output logic          out_valid,
	input  logic          out_ready,
	output mf_pkg::job_t  out_job
);

	localparam int PtrW = $clog2(mf_pkg::FifoDepth);
	localparam int CntW = $clog2(mf_pkg::FifoDepth + 1);

	mf_pkg::job_t          slot_q [mf_pkg::FifoDepth];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [CntW-1:0]       count_q;
	logic                  push;
	logic                  pop;

	assign in_ready  = (count_q != CntW'(mf_pkg::FifoDepth));
	assign out_valid = (count_q != '0);
	assign out_job   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			count_q <= count_q + CntW'(push) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= in_job;
	end

endmodule

@@ sv/mf_window.sv @@
module mf_window (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           job_valid,
	output logic           job_ready,
	input  mf_pkg::job_t   job,
	output logic           win_valid,
	output mf_pkg::win9_t  win,
	output logic           win_last
);

	localparam mf_pkg::col_t ZeroCol = '0;

	mf_pkg::pix_t   upper_line_q  [mf_pkg::MaxWidth];
	mf_pkg::pix_t   middle_line_q [mf_pkg::MaxWidth];

	logic           valid_s1;
	mf_pkg::job_t   job_s1;
	mf_pkg::pix_t   up_rd_s1;
	mf_pkg::pix_t   mid_rd_s1;
	logic           fwd_s1;
	mf_pkg::pix_t   fwd_up_s1;
	mf_pkg::pix_t   fwd_mid_s1;

	logic           valid_s2;
	mf_pkg::win9_t  win_s2;
	logic           last_s2;

	mf_pkg::win9_t  win_q;

	logic           pop;
	logic           wr;
	mf_pkg::pix_t   up_eff;
	mf_pkg::pix_t   mid_eff;
	mf_pkg::col_t   new_col;

	assign job_ready = en;
	assign pop       = en && job_valid;
	assign wr        = en && valid_s1;

	// Back-to-back items on the same column (width 1) see the write in flight
	always_comb begin
		up_eff  = '0;
		mid_eff = '0;
		if (job_s1.use_up)
			up_eff = fwd_s1 ? fwd_up_s1 : up_rd_s1;
		if (job_s1.use_mid)
			mid_eff = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;
		new_col = {job_s1.pix, mid_eff, up_eff};
	end

	always_ff @(posedge clk) begin
		if (pop)
			up_rd_s1 <= upper_line_q[job.col];
		if (wr)
			upper_line_q[job_s1.col] <= mid_eff;
	end

	always_ff @(posedge clk) begin
		if (pop)
			mid_rd_s1 <= middle_line_q[job.col];
		if (wr)
			middle_line_q[job_s1.col] <= job_s1.pix;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_s1     <= job;
			fwd_s1     <= valid_s1 && (job_s1.col == job.col);
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= job_s1.pix;
		end
		if (wr) begin
			win_s2  <= {(job_s1.first_col ? ZeroCol : new_col), win_q[8:3]};
			last_s2 <= job_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			win_q    <= '0;
		end else if (en) begin
			valid_s1 <= job_valid;
			valid_s2 <= valid_s1 && job_s1.emit;
			if (valid_s1)
				win_q <= job_s1.first_col ? {new_col, ZeroCol, ZeroCol}
				                          : {new_col, win_q[8:3]};
		end
	end

	assign win_valid = valid_s2;
	assign win       = win_s2;
	assign win_last  = last_s2;

endmodule

@@ sv/mf_median.sv @@
module mf_median (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  mf_pkg::win9_t  in_win,
	input  logic           in_last,
	output logic           out_valid,
	output mf_pkg::pix_t   out_median,
	output logic           out_last
);

	// Nine-input median network, three compare layers per stage
	function automatic mf_pkg::win9_t cx(mf_pkg::win9_t p, int a, int b);
		mf_pkg::win9_t q;
		q = p;
		if (p[a] > p[b]) begin
			q[a] = p[b];
			q[b] = p[a];
		end
		return q;
	endfunction

	logic           valid_s1, valid_s2, valid_s3;
	mf_pkg::win9_t  p_s1, p_s2;
	logic           last_s1, last_s2, last_s3;
	mf_pkg::pix_t   med_s3;
	mf_pkg::win9_t  a, b, c;

	always_comb begin
		// sort each column triple
		a = in_win;
		a = cx(a, 1, 2); a = cx(a, 4, 5); a = cx(a, 7, 8);
		a = cx(a, 0, 1); a = cx(a, 3, 4); a = cx(a, 6, 7);
		a = cx(a, 1, 2); a = cx(a, 4, 5); a = cx(a, 7, 8);
		b = p_s1;
		b = cx(b, 0, 3); b = cx(b, 5, 8); b = cx(b, 4, 7);
		b = cx(b, 3, 6); b = cx(b, 1, 4); b = cx(b, 2, 5);
		b = cx(b, 4, 7);
		c = p_s2;
		c = cx(c, 4, 2);
		c = cx(c, 6, 4);
		c = cx(c, 4, 2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= a;
			last_s1 <= in_last;
			p_s2    <= b;
			last_s2 <= last_s1;
			med_s3  <= c[4];
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid  = valid_s3;
	assign out_median = med_s3;
	assign out_last   = last_s3;

endmodule

@@ sv/median_filter_3x3.sv @@
// Channel   Role    Payload                         Handshake
// pixels    sink    opcode, pixel                   valid / ready
// medians   source  median_value, last_of_frame     valid / ready
// cfg       sink    index, data                     valid / ready (ready tied high)
//
// One item per clock sustained while no result waits on medians.ready; a result
// is registered through the queue, the window stage and the median network.
// The front end classifies each item against the row/column counters and
// pushes it into a four-entry queue; ready drops only when that queue is full.
// The back end (line stores, window, median network, output register) moves
// as one pipeline that stalls only while a result waits on medians.ready.
// Reset clears counters, window and valid bits; line stores need no clearing.
module median_filter_3x3 (
	input  logic       clk,
	input  logic       arst_n,
	mf_in_if.sink      pixels,
	mf_out_if.source   medians,
	mf_cfg_if.sink     cfg
);

	// front end -> queue
	logic           f_valid;
	logic           f_ready;
	mf_pkg::job_t   f_job;

	// queue -> window stage
	logic           q_valid;
	logic           q_ready;
	mf_pkg::job_t   q_job;

	// window stage -> median network
	logic           w_valid;
	mf_pkg::win9_t  w_win;
	logic           w_last;

	// median network output register
	logic           m_valid;
	mf_pkg::pix_t   m_median;
	logic           m_last;

	// Back end advances unless a finished result is held up downstream
	logic           en;
	assign en = !m_valid || medians.ready;

	mf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.cfg       (cfg),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	mf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_job    (f_job),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_job   (q_job)
	);

	// Line stores: read on pop, written back from stage s1 with forwarding for
	// same-column neighbors; window column shift or restart at column zero.
	mf_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.win_valid (w_valid),
		.win       (w_win),
		.win_last  (w_last)
	);

	mf_median u_median (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (w_valid),
		.in_win     (w_win),
		.in_last    (w_last),
		.out_valid  (m_valid),
		.out_median (m_median),
		.out_last   (m_last)
	);

	assign medians.valid         = m_valid;
	assign medians.median_value  = m_median;
	assign medians.last_of_frame = m_last;

endmodule

@@ sv/mf_checker.sv @@
module mf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	logic [31:0] pending_q;
	logic        in_acc;
	logic        out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else
			pending_q <= pending_q + 32'(in_acc) - 32'(out_acc);
	end

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// no result without an item accepted before it
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != '0)
		else $error("more results than items");

	// input side backs up only behind an output stall
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input stalled without output backpressure");

endmodule

bind median_filter_3x3 mf_checker u_mf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (medians.valid),
	.out_ready (medians.ready)
);

@@ tb/median_filter_3x3_test.sv @@
module median_filter_3x3_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ResetCycles  = 9;
	localparam int SettleCycles = 12;      // pipeline depth plus queue, with margin
	localparam int RandomItems  = 250;
	localparam int DrainLimit   = 10000;
	localparam int LimitNs      = 20_000_000;

	// One expected result: median plus end-of-frame flag
	typedef struct packed {
		mf_pkg::pix_t median;
		logic         last;
	} median_result_t;

	logic clk;
	logic arst_n;

	mf_in_if  pix_ch();
	mf_out_if med_ch();
	mf_cfg_if cfg_ch();

	median_filter_3x3 u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_ch),
		.medians(med_ch),
		.cfg    (cfg_ch)
	);

	// ------------------------------------------------------------------
	// Filter state mirror: line stores, window columns, raster counters
	// and the two geometry registers, all at the block's widths.
	// ------------------------------------------------------------------
	mf_pkg::pix_t                    upper_store  [mf_pkg::MaxWidth];
	mf_pkg::pix_t                    middle_store [mf_pkg::MaxWidth];
	mf_pkg::col_t                    win_cols     [3];   // [0] oldest column, [2] newest
	logic [mf_pkg::RowW-1:0]         row_pos    = '0;
	logic [mf_pkg::AddrW-1:0]        col_pos    = '0;
	logic [mf_pkg::WidthW-1:0]       width_reg  = mf_pkg::WidthReset;
	logic [mf_pkg::HeightW-1:0]      height_reg = mf_pkg::HeightReset;

	median_result_t medians_due[$];

	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	bit          steady     = 0;     // no gaps on either side while set
	bit          pix_held   = 0;     // pixels.valid still high from last item

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop far beyond the slowest legal run
	initial begin
		#(LimitNs);
		$display("TEST FAILED");
		$finish;
	end

	function automatic mf_pkg::pix_t median_of_nine(mf_pkg::win9_t nine);
		mf_pkg::pix_t swap;
		for (int i = 0; i < 8; i++)
			for (int j = 0; j < 8 - i; j++)
				if (nine[j] > nine[j+1]) begin
					swap      = nine[j];
					nine[j]   = nine[j+1];
					nine[j+1] = swap;
				end
		return nine[4];
	endfunction

	// Append one expectation at the tail of the result queue
	function automatic void expect_median(mf_pkg::pix_t value, logic is_last);
		median_result_t entry;
		entry.median = value;
		entry.last   = is_last;
		medians_due  = {medians_due, entry};
	endfunction

	// Advance the mirror by one accepted item and queue what it yields
	function automatic void advance_filter(mf_pkg::op_t op, mf_pkg::pix_t px);
		int unsigned w, h, r, c;
		mf_pkg::pix_t v, up, mid;
		logic last;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > mf_pkg::MaxWidth) w = mf_pkg::MaxWidth;
		h = height_reg;
		if (h < 1) h = 1;
		r = row_pos;
		c = col_pos;
		// column past a shrunk width: this item closes the row
		if (c >= w) c = w - 1;

		// drains and anything past the last row are zero pixels
		v   = (op == mf_pkg::OP_PIXEL && r < h) ? px : '0;
		// rows above the frame read as zero
		up  = (r >= 2) ? upper_store[c]  : '0;
		mid = (r >= 1) ? middle_store[c] : '0;
		upper_store[c]  = mid;
		middle_store[c] = v;

		last = 1'b0;
		if (c == 0) begin
			// wrap: finish the previous row's rightmost center, right column is padding
			if (r >= 2 && r <= h + 1) begin
				last = (r == h + 1);
				expect_median(median_of_nine({mf_pkg::col_t'('0), win_cols[2],
					win_cols[1]}), last);
			end
			win_cols[0] = '0;
			win_cols[1] = '0;
		end else begin
			win_cols[0] = win_cols[1];
			win_cols[1] = win_cols[2];
		end
		win_cols[2] = {v, mid, up};

		if (c != 0 && r >= 1 && r <= h)
			expect_median(median_of_nine({win_cols[2], win_cols[1], win_cols[0]}),
				1'b0);

		if (last) begin
			r = 0;
			c = 0;
		end else if (c + 1 >= w) begin
			c = 0;
			r++;
		end else begin
			c++;
		end
		// row beyond a shrunk height: frame dropped without a result
		if (r > h + 1) begin
			r = 0;
			c = 0;
		end
		row_pos = mf_pkg::RowW'(r);
		col_pos = mf_pkg::AddrW'(c);
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned idle_len();
		int unsigned roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Full range, extremes, and a narrow band so ties show up in the sort
	function automatic mf_pkg::pix_t pick_pixel();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			2, 3:    return mf_pkg::pix_t'($urandom_range(120, 136));
			default: return mf_pkg::pix_t'($urandom);
		endcase
	endfunction

	function automatic logic [mf_pkg::CfgDataW-1:0] pick_width();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 75) return mf_pkg::CfgDataW'($urandom_range(1, 8));
		if (roll < 95) return mf_pkg::CfgDataW'($urandom_range(9, 24));
		if (roll < 98) return mf_pkg::CfgDataW'($urandom_range(25, 40));
		return '0;
	endfunction

	function automatic logic [mf_pkg::CfgDataW-1:0] pick_height();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) return mf_pkg::CfgDataW'($urandom_range(1, 5));
		if (roll < 95) return mf_pkg::CfgDataW'($urandom_range(6, 12));
		return '0;
	endfunction

	// Lower pixels.valid if the last item left it up
	task automatic drop_valid();
		if (pix_held) begin
			pix_ch.valid <= 1'b0;
			pix_held = 0;
		end
	endtask

	// Wait for every result, then for anything still in the pipe
	task automatic settle();
		drop_valid();
		while (medians_due.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic send_item(mf_pkg::op_t op, mf_pkg::pix_t px);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			drop_valid();
			repeat (gap) @(posedge clk);
		end
		// valid stays up when the next item follows directly
		pix_ch.valid  <= 1'b1;
		pix_ch.opcode <= op;
		pix_ch.pixel  <= px;
		@(posedge clk);
		while (pix_ch.ready !== 1'b1) @(posedge clk);
		pix_held = 1;
		advance_filter(op, px);
		items_sent++;
	endtask

	task automatic write_register(mf_pkg::reg_idx_t idx,
			logic [mf_pkg::CfgDataW-1:0] value);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		case (idx)
			mf_pkg::REG_WIDTH:  width_reg  = value[mf_pkg::WidthW-1:0];
			mf_pkg::REG_HEIGHT: height_reg = value[mf_pkg::HeightW-1:0];
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Whole frame at the current geometry: pixels, then width+1 tail items.
	// hole_pct: drains inside the frame; junk_pct: pixel items in the tail.
	// At item pause_at the sender holds off until every median is back.
	task automatic run_frame(int unsigned hole_pct, int unsigned junk_pct, int pause_at);
		int unsigned cols, rows, body;
		cols = (width_reg == 0) ? 1 :
		       ((width_reg > mf_pkg::MaxWidth) ? mf_pkg::MaxWidth : width_reg);
		rows = (height_reg == 0) ? 1 : height_reg;
		body = cols * rows;
		for (int k = 0; k < body + cols + 1; k++) begin
			if (k == pause_at) begin
				drop_valid();
				@(posedge clk);
				while (medians_due.size() != 0) @(posedge clk);
			end
			if (k < body)
				send_item(($urandom_range(1, 100) <= hole_pct) ?
					mf_pkg::OP_DRAIN : mf_pkg::OP_PIXEL, pick_pixel());
			else
				send_item(($urandom_range(1, 100) <= junk_pct) ?
					mf_pkg::OP_PIXEL : mf_pkg::OP_DRAIN, pick_pixel());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Geometry left at reset: one full row plus two items of the next shows
	// the first median; then width 2 / height 1 close the frame in two items
	task automatic test_reset_width();
		repeat (int'(mf_pkg::WidthReset) + 2) send_item(mf_pkg::OP_PIXEL, pick_pixel());
		write_register(mf_pkg::REG_WIDTH, 16'd2);
		write_register(mf_pkg::REG_HEIGHT, 16'd1);
		repeat (2) send_item(mf_pkg::OP_PIXEL, pick_pixel());
	endtask

	task automatic test_directed_corners();
		// 3x3 frame: extremes, alternating bits, a hole, junk past the end
		write_register(mf_pkg::REG_WIDTH, 16'd3);
		write_register(mf_pkg::REG_HEIGHT, 16'd3);
		send_item(mf_pkg::OP_PIXEL, 8'h00);
		send_item(mf_pkg::OP_PIXEL, 8'hFF);
		send_item(mf_pkg::OP_PIXEL, 8'hAA);
		send_item(mf_pkg::OP_DRAIN, 8'h5A);   // hole in the frame: zero pixel
		send_item(mf_pkg::OP_PIXEL, 8'h55);
		send_item(mf_pkg::OP_PIXEL, 8'hFF);
		send_item(mf_pkg::OP_PIXEL, 8'h01);
		send_item(mf_pkg::OP_PIXEL, 8'h80);
		send_item(mf_pkg::OP_PIXEL, 8'hFF);
		send_item(mf_pkg::OP_DRAIN, 8'h00);
		send_item(mf_pkg::OP_PIXEL, 8'hC3);   // past frame end: value dropped
		send_item(mf_pkg::OP_DRAIN, 8'hFF);
		send_item(mf_pkg::OP_DRAIN, 8'h00);
		// zero width and zero height both act as one
		write_register(mf_pkg::REG_WIDTH, 16'd0);
		write_register(mf_pkg::REG_HEIGHT, 16'd0);
		send_item(mf_pkg::OP_PIXEL, 8'hFE);
		send_item(mf_pkg::OP_DRAIN, 8'h7F);
		send_item(mf_pkg::OP_DRAIN, 8'h80);
		// width field is 11 bits: upper data bits fall away, width 2
		write_register(mf_pkg::REG_WIDTH, 16'hF802);
		write_register(mf_pkg::REG_HEIGHT, 16'd1);
		send_item(mf_pkg::OP_PIXEL, 8'h7F);
		send_item(mf_pkg::OP_PIXEL, 8'h81);
		repeat (3) send_item(mf_pkg::OP_DRAIN, 8'h00);
	endtask

	task automatic test_midframe_changes();
		// 4x4 frame, stop at row 1 column 3, then shrink width to 2:
		// the next item ends that row at once
		write_register(mf_pkg::REG_WIDTH, 16'd4);
		write_register(mf_pkg::REG_HEIGHT, 16'd4);
		repeat (7) send_item(mf_pkg::OP_PIXEL, pick_pixel());
		write_register(mf_pkg::REG_WIDTH, 16'd2);
		repeat (5) send_item(mf_pkg::OP_PIXEL, pick_pixel());
		repeat (3) send_item(mf_pkg::OP_DRAIN, pick_pixel());
		// tallest height, three rows in, then height cut to 1:
		// the next item is swallowed and the counters wrap to zero
		write_register(mf_pkg::REG_HEIGHT, 16'hFFFF);
		repeat (6) send_item(mf_pkg::OP_PIXEL, pick_pixel());
		write_register(mf_pkg::REG_HEIGHT, 16'd1);
		send_item(mf_pkg::OP_PIXEL, pick_pixel());
		run_frame(0, 0, -1);
	endtask

	task automatic test_full_rate();
		// rows at full rate on both sides, with a hold-off mid row
		steady = 1;
		write_register(mf_pkg::REG_WIDTH, 16'd40);
		write_register(mf_pkg::REG_HEIGHT, 16'd2);
		run_frame(0, 0, 50);
		steady = 0;
	endtask

	task automatic test_random_frames();
		int unsigned start;
		int pause_at;
		bit first;
		first = 1;
		start = items_sent;
		while (items_sent - start < RandomItems) begin
			if (first || $urandom_range(0, 3) != 0)
				write_register(mf_pkg::REG_WIDTH, pick_width());
			if (first || $urandom_range(0, 3) != 0)
				write_register(mf_pkg::REG_HEIGHT, pick_height());
			steady = ($urandom_range(0, 6) == 0);
			if (first)
				pause_at = 3;
			else if ($urandom_range(0, 4) == 0)
				pause_at = $urandom_range(0, 20);
			else
				pause_at = -1;
			run_frame(($urandom_range(0, 2) == 0) ? 15 : 0,
				($urandom_range(0, 2) == 0) ? 30 : 0, pause_at);
			first = 0;
		end
		steady = 0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure on medians.ready
	// ------------------------------------------------------------------
	initial begin : drive_result_ready
		int unsigned stall;
		med_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_len();
			if (stall != 0) begin
				med_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			med_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Every accepted median against the oldest outstanding expectation
	always @(posedge clk) begin : check_medians
		median_result_t want;
		if (arst_n === 1'b1 && med_ch.valid === 1'b1 && med_ch.ready === 1'b1) begin
			if (medians_due.size() == 0) begin
				$error("median_value %0d last_of_frame %0b arrived with none expected",
					med_ch.median_value, med_ch.last_of_frame);
				mismatches++;
			end else begin
				want = medians_due.pop_front();
				if (med_ch.median_value !== want.median) begin
					$error("median_value: expected %0d, got %0d",
						want.median, med_ch.median_value);
					mismatches++;
				end
				if (med_ch.last_of_frame !== want.last) begin
					$error("last_of_frame: expected %0b, got %0b",
						want.last, med_ch.last_of_frame);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned drain_wait;
		arst_n        <= 1'b0;
		pix_ch.valid  <= 1'b0;
		pix_ch.opcode <= mf_pkg::OP_PIXEL;
		pix_ch.pixel  <= '0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= mf_pkg::REG_WIDTH;
		cfg_ch.data   <= '0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_width();
		test_directed_corners();
		test_midframe_changes();
		test_full_rate();
		test_random_frames();

		// all items in: let the last medians come back, then watch for strays
		drop_valid();
		@(posedge clk);
		drain_wait = 0;
		while (medians_due.size() != 0 && drain_wait < DrainLimit) begin
			@(posedge clk);
			drain_wait++;
		end
		if (medians_due.size() != 0) begin
			$error("%0d expected medians never arrived", medians_due.size());
			mismatches++;
		end
		repeat (SettleCycles) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
